// ----- hw/rtl/tmcs_pkg.sv -----
// types and constants shared by the texture mip chain sizer
package tmcs_pkg;

  // default and ceiling of the level count
  localparam int unsigned MaxLevelsDef = 16;

  // format codes
  localparam logic [1:0] FMT_RAW  = 2'd0;
  localparam logic [1:0] FMT_DXT1 = 2'd1;

  // bytes per 4x4 block for the compressed formats
  localparam logic [4:0] DXT1_BLOCK_BYTES = 5'd8;
  localparam logic [4:0] DXT_BLOCK_BYTES  = 5'd16;

  // input word: one texture descriptor
  typedef struct packed {
    logic [14:0] base_width;
    logic [14:0] base_height;
    logic [11:0] layer_depth;
    logic [4:0]  mip_count;
    logic [1:0]  format_kind;
    logic [4:0]  pixel_bytes;
    logic [1:0]  align_log2;
    logic        is_animated;
  } tmcs_in_t;

  // output word: one mip level
  typedef struct packed {
    logic [3:0]  level_number;
    logic [14:0] level_width;
    logic [14:0] level_height;
    logic [14:0] blocks_across;
    logic [14:0] blocks_down;
    logic [4:0]  bytes_per_block;
    logic [18:0] row_pitch;
    logic [32:0] slice_pitch;
    logic [47:0] total_bytes;
    logic        last;
  } tmcs_out_t;

endpackage

// ----- hw/rtl/texture_mip_chain_sizer_core.sv -----
// texture mip chain sizer: per-level sizes and pitches from one descriptor
//
//  channel | direction | word         | handshake
//  --------+-----------+--------------+-------------------------
//  in      | input     | tmcs_in_t    | in_valid_i / in_ready_o
//  out     | output    | tmcs_out_t   | out_valid_o / out_ready_i
//
// each level steps through the row, slice and emit states around one shared 24x15
// multiplier; the last level of an animated texture also passes the low and high
// depth scaling states before its emit.
// a zero mip count gives one word, marked last, with every other field zero.
// reset clears the sequencer and the output valid; data registers are not reset.
// a stalled output holds the sequencer in its emit step; a new descriptor is
// taken while the last word of the previous one still waits.
module texture_mip_chain_sizer_core
  import tmcs_pkg::*;
#(
  parameter int unsigned MAX_LEVELS = MaxLevelsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  tmcs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output tmcs_out_t out_data_o
);

  localparam logic [4:0] MaxCnt = 5'(MAX_LEVELS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ROW    = 3'd1;
  localparam logic [2:0] S_SLICE  = 3'd2;
  localparam logic [2:0] S_SCL_LO = 3'd3;
  localparam logic [2:0] S_SCL_HI = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [3:0]  lv_q, lv_d;
  logic        zero_q, zero_d;

  // held descriptor
  logic [14:0] bw_q, bh_q;
  logic [11:0] depth_q;
  logic [4:0]  cnt_q;
  logic [1:0]  fmt_q;
  logic [4:0]  pb_q;
  logic [1:0]  al_q;
  logic        anim_q;

  // datapath registers
  logic [19:0] row_q, row_d;
  logic [34:0] slice_q, slice_d;
  logic [47:0] total_q, total_d;
  logic [47:0] scale_q, scale_d;

  logic        out_valid_q;
  tmcs_out_t   out_q;

  // per-level geometry
  logic [14:0] w_sh, h_sh, w, h, ba, bd;
  logic [15:0] w_p3, h_p3;
  logic [4:0]  bpb;
  logic        is_last;
  logic [4:0]  cnt_in;

  always_comb begin
    w_sh = bw_q >> lv_q;
    h_sh = bh_q >> lv_q;
    w    = (w_sh == '0) ? 15'd1 : w_sh;
    h    = (h_sh == '0) ? 15'd1 : h_sh;
    w_p3 = {1'b0, w} + 16'd3;
    h_p3 = {1'b0, h} + 16'd3;
    if (fmt_q == FMT_RAW) begin
      ba  = w;
      bd  = h;
      bpb = pb_q;
    end else begin
      ba  = w_p3[15:2] == '0 ? 15'd1 : {1'b0, w_p3[15:2]};
      bd  = h_p3[15:2] == '0 ? 15'd1 : {1'b0, h_p3[15:2]};
      bpb = (fmt_q == FMT_DXT1) ? DXT1_BLOCK_BYTES : DXT_BLOCK_BYTES;
    end
    is_last = ({1'b0, lv_q} + 5'd1) == cnt_q;
  end

  // shared multiplier with operand select
  logic [23:0] mul_a;
  logic [14:0] mul_b;
  logic [38:0] mul_p;

  always_comb begin
    case (state_q)
      S_ROW: begin
        mul_a = {9'd0, w};
        mul_b = {10'd0, pb_q};
      end
      S_SLICE: begin
        mul_a = {4'd0, row_q};
        mul_b = bd;
      end
      S_SCL_LO: begin
        mul_a = total_q[23:0];
        mul_b = {3'd0, depth_q};
      end
      S_SCL_HI: begin
        mul_a = total_q[47:24];
        mul_b = {3'd0, depth_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = {15'd0, mul_a} * {24'd0, mul_b};

  // row pitch: aligned product for raw pixels, block count times block bytes for dxt
  logic [20:0] row_rnd;
  logic [20:0] row_aln;

  always_comb begin
    row_rnd = {1'b0, mul_p[19:0]} + ((21'd1 << al_q) - 21'd1);
    row_aln = (row_rnd >> al_q) << al_q;
  end

  // output handoff
  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    lv_d    = lv_q;
    zero_d  = zero_q;
    row_d   = row_q;
    slice_d = slice_q;
    total_d = total_q;
    scale_d = scale_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          lv_d    = '0;
          total_d = '0;
          zero_d  = (in_data_i.mip_count == '0);
          state_d = (in_data_i.mip_count == '0) ? S_EMIT : S_ROW;
        end
      end
      S_ROW: begin
        if (fmt_q == FMT_RAW) begin
          row_d = row_aln[19:0];
        end else if (fmt_q == FMT_DXT1) begin
          row_d = {5'd0, ba} << 3;
        end else begin
          row_d = {5'd0, ba} << 4;
        end
        state_d = S_SLICE;
      end
      S_SLICE: begin
        slice_d = mul_p[34:0];
        total_d = total_q + {13'd0, mul_p[34:0]};
        state_d = (is_last && anim_q) ? S_SCL_LO : S_EMIT;
      end
      S_SCL_LO: begin
        scale_d = {9'd0, mul_p};
        state_d = S_SCL_HI;
      end
      S_SCL_HI: begin
        total_d = scale_q + {mul_p[23:0], 24'd0};
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          if (zero_q || is_last) begin
            state_d = S_IDLE;
          end else begin
            lv_d    = lv_q + 4'd1;
            state_d = S_ROW;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);

  // descriptor capture with level count saturation
  assign cnt_in = (in_data_i.mip_count > MaxCnt) ? MaxCnt : in_data_i.mip_count;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      bw_q    <= in_data_i.base_width;
      bh_q    <= in_data_i.base_height;
      depth_q <= in_data_i.layer_depth;
      cnt_q   <= cnt_in;
      fmt_q   <= in_data_i.format_kind;
      pb_q    <= in_data_i.pixel_bytes;
      al_q    <= in_data_i.align_log2;
      anim_q  <= in_data_i.is_animated;
    end
    row_q   <= row_d;
    slice_q <= slice_d;
    total_q <= total_d;
    scale_q <= scale_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lv_q    <= '0;
      zero_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lv_q    <= lv_d;
      zero_q  <= zero_d;
    end
  end

  // output word register
  tmcs_out_t res;

  always_comb begin
    if (zero_q) begin
      res      = '0;
      res.last = 1'b1;
    end else begin
      res.level_number    = lv_q;
      res.level_width     = w;
      res.level_height    = h;
      res.blocks_across   = ba;
      res.blocks_down     = bd;
      res.bytes_per_block = bpb;
      res.row_pitch       = row_q[19] ? '1 : row_q[18:0];
      res.slice_pitch     = (slice_q[34:33] != '0) ? '1 : slice_q[32:0];
      res.total_bytes     = total_q;
      res.last            = is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // checks
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q != S_IDLE)
    else $error("sequencer idle after accepting a descriptor");

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) && !zero_q |-> ({1'b0, lv_q} < cnt_q))
    else $error("level counter beyond the level count");

  a_zero_width_only_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.level_width == '0) |->
      out_data_o.last && (out_data_o.total_bytes == '0))
    else $error("zero width outside an empty descriptor result");

  a_emit_holds_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && out_valid_o && !out_ready_i |=> state_q == S_EMIT)
    else $error("sequencer left emit while output stalled");

endmodule

// ----- verif/texture_mip_chain_sizer_core_test.sv -----
// self-checking testbench for the texture mip chain sizer core
module texture_mip_chain_sizer_core_test;
  import tmcs_pkg::*;

  // format codes not named in the package
  localparam logic [1:0] FMT_DXT     = 2'd2;
  localparam logic [1:0] FMT_DXT_ALT = 2'd3;

  localparam int unsigned NumDirected  = 24;
  localparam int unsigned NumRandom    = 436;
  localparam int unsigned HoldOffLen   = 500;
  localparam int unsigned HoldOffAt    = 150;
  localparam int unsigned DrainCycles  = 20;
  localparam int unsigned StallLimit   = 4000;
  localparam logic [63:0] Mask48       = 64'hFFFF_FFFF_FFFF;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  tmcs_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  tmcs_out_t out_data_o;

  // one directed descriptor, with a hand-written level where it is obvious
  typedef struct {
    tmcs_in_t  desc;
    bit        has_golden;
    tmcs_out_t golden;
  } table_row_t;

  tmcs_out_t   pending_levels [$];
  table_row_t  directed_rows [NumDirected];
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;

  texture_mip_chain_sizer_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic tmcs_in_t descr(logic [14:0] bw, logic [14:0] bh, logic [11:0] depth,
                                     logic [4:0] count, logic [1:0] fmt, logic [4:0] pb,
                                     logic [1:0] al, logic anim);
    descr.base_width  = bw;
    descr.base_height = bh;
    descr.layer_depth = depth;
    descr.mip_count   = count;
    descr.format_kind = fmt;
    descr.pixel_bytes = pb;
    descr.align_log2  = al;
    descr.is_animated = anim;
  endfunction

  // single-level chain: level zero, marked last
  function automatic tmcs_out_t one_level(logic [14:0] w, logic [14:0] h, logic [14:0] ba,
                                          logic [14:0] bd, logic [4:0] bpb, logic [18:0] row,
                                          logic [32:0] slice, logic [47:0] total);
    one_level.level_number    = '0;
    one_level.level_width     = w;
    one_level.level_height    = h;
    one_level.blocks_across   = ba;
    one_level.blocks_down     = bd;
    one_level.bytes_per_block = bpb;
    one_level.row_pitch       = row;
    one_level.slice_pitch     = slice;
    one_level.total_bytes     = total;
    one_level.last            = 1'b1;
  endfunction

  // expected level words of one descriptor
  function automatic void size_mip_chain(input tmcs_in_t d);
    tmcs_out_t   lvl;
    int unsigned levels;
    int unsigned lv;
    logic [63:0] w, h, ba, bd, bpb, row, slice, sum, pad;
    if (d.mip_count == 0) begin
      lvl      = '0;
      lvl.last = 1'b1;
      pending_levels.push_back(lvl);
      return;
    end
    levels = (d.mip_count > MaxLevelsDef) ? MaxLevelsDef : d.mip_count;
    sum    = '0;
    for (lv = 0; lv < levels; lv++) begin
      w = 64'(d.base_width) >> lv;
      h = 64'(d.base_height) >> lv;
      if (w == 0) w = 1;
      if (h == 0) h = 1;
      if (d.format_kind == FMT_RAW) begin
        ba  = w;
        bd  = h;
        bpb = 64'(d.pixel_bytes);
        pad = (64'd1 << d.align_log2) - 1;
        row = (w * bpb + pad) & ~pad;
      end else begin
        ba  = (w + 3) / 4;
        bd  = (h + 3) / 4;
        bpb = (d.format_kind == FMT_DXT1) ? 64'(DXT1_BLOCK_BYTES) : 64'(DXT_BLOCK_BYTES);
        row = ba * bpb;
      end
      slice = row * bd;
      sum   = (sum + slice) & Mask48;

      lvl.level_number    = lv[3:0];
      lvl.level_width     = w[14:0];
      lvl.level_height    = h[14:0];
      lvl.blocks_across   = ba[14:0];
      lvl.blocks_down     = bd[14:0];
      lvl.bytes_per_block = bpb[4:0];
      lvl.row_pitch       = (row > 64'h7_FFFF) ? '1 : row[18:0];
      lvl.slice_pitch     = (slice > 64'h1_FFFF_FFFF) ? '1 : slice[32:0];
      lvl.last            = (lv + 1 == levels);
      // animated textures scale the final total by the depth
      if (lvl.last && d.is_animated) lvl.total_bytes = 48'(sum * 64'(d.layer_depth));
      else lvl.total_bytes = sum[47:0];
      pending_levels.push_back(lvl);
    end
  endfunction

  // random extent: mostly small, some powers of two, some across the full field
  function automatic logic [14:0] pick_extent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_extent = 15'($urandom_range(1, 64));
      4, 5:       pick_extent = 15'(1 << $urandom_range(0, 14));
      6, 7:       pick_extent = 15'($urandom_range(0, 16384));
      default:    pick_extent = 15'($urandom);
    endcase
  endfunction

  task automatic check_field(input string name, input logic [47:0] want, input logic [47:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // offer one descriptor word after a gap; record what it should produce once taken
  task automatic send_word(input tmcs_in_t d, input int unsigned gap, input bit has_golden,
                           input tmcs_out_t golden);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (has_golden) pending_levels.push_back(golden);
    else size_mip_chain(d);
    @(negedge clk_i);
  endtask

  // compare each taken level word with the oldest expectation; watchdog
  always @(posedge clk_i) begin
    tmcs_out_t want;
    if (out_valid_o && out_ready_i) begin
      if (pending_levels.size() == 0) begin
        $error("level word with nothing expected: level %0d", out_data_o.level_number);
        fail_count++;
      end else begin
        want = pending_levels.pop_front();
        check_field("level_number", 48'(want.level_number), 48'(out_data_o.level_number));
        check_field("level_width", 48'(want.level_width), 48'(out_data_o.level_width));
        check_field("level_height", 48'(want.level_height), 48'(out_data_o.level_height));
        check_field("blocks_across", 48'(want.blocks_across), 48'(out_data_o.blocks_across));
        check_field("blocks_down", 48'(want.blocks_down), 48'(out_data_o.blocks_down));
        check_field("bytes_per_block", 48'(want.bytes_per_block),
                    48'(out_data_o.bytes_per_block));
        check_field("row_pitch", 48'(want.row_pitch), 48'(out_data_o.row_pitch));
        check_field("slice_pitch", 48'(want.slice_pitch), 48'(out_data_o.slice_pitch));
        check_field("total_bytes", want.total_bytes, out_data_o.total_bytes);
        check_field("last", 48'(want.last), 48'(out_data_o.last));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == StallLimit) begin
      $display("** texture_mip_chain_sizer_core: FAILED **");
      $finish;
    end
  end

  // result side: random stalls, quiet stretches, one long hold-off
  initial begin
    int unsigned gap;
    int unsigned taken;
    out_ready_i = 1'b0;
    taken       = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == HoldOffAt) gap = HoldOffLen;
      else if ((taken % 97) < 15) gap = 0;
      else gap = $urandom_range(0, 13);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
      @(negedge clk_i);
    end
  end

  // descriptor side: directed table, then random descriptors
  initial begin
    int unsigned gap;
    int unsigned i;
    tmcs_in_t    desc;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;

    directed_rows = '{
      // zero mip count, quiet and with every other field at its top
      '{descr(0, 0, 0, 0, FMT_RAW, 0, 0, 0), 1'b1, one_level(0, 0, 0, 0, 0, 0, 0, 0)},
      '{descr(15'h7FFF, 15'h7FFF, 12'hFFF, 0, FMT_DXT_ALT, 31, 3, 1), 1'b1,
        one_level(0, 0, 0, 0, 0, 0, 0, 0)},
      // single texel in each format
      '{descr(1, 1, 1, 1, FMT_RAW, 4, 0, 0), 1'b1, one_level(1, 1, 1, 1, 4, 4, 4, 4)},
      '{descr(1, 1, 1, 1, FMT_DXT1, 4, 3, 0), 1'b1, one_level(1, 1, 1, 1, 8, 8, 8, 8)},
      '{descr(1, 1, 1, 1, FMT_DXT, 4, 3, 0), 1'b1, one_level(1, 1, 1, 1, 16, 16, 16, 16)},
      '{descr(1, 1, 1, 1, FMT_DXT_ALT, 0, 0, 0), 1'b1, one_level(1, 1, 1, 1, 16, 16, 16, 16)},
      // zero pixel bytes
      '{descr(1, 1, 1, 1, FMT_RAW, 0, 2, 0), 1'b1, one_level(1, 1, 1, 1, 0, 0, 0, 0)},
      // animated with zero depth and with depth 2048
      '{descr(1, 1, 0, 1, FMT_RAW, 4, 0, 1), 1'b1, one_level(1, 1, 1, 1, 4, 4, 4, 0)},
      '{descr(1, 1, 2048, 1, FMT_RAW, 4, 0, 1), 1'b1, one_level(1, 1, 1, 1, 4, 4, 4, 8192)},
      // zero extents clamp to one
      '{descr(0, 0, 5, 1, FMT_RAW, 1, 0, 0), 1'b1, one_level(1, 1, 1, 1, 1, 1, 1, 1)},
      // row rounded up to eight bytes
      '{descr(1, 1, 1, 1, FMT_RAW, 1, 3, 0), 1'b1, one_level(1, 1, 1, 1, 1, 8, 8, 8)},
      // full chains at the extremes, pitch saturation
      '{descr(16384, 16384, 2048, 16, FMT_RAW, 16, 3, 1), 1'b0, '0},
      '{descr(32767, 32767, 4095, 31, FMT_RAW, 31, 3, 1), 1'b0, '0},
      '{descr(32767, 32767, 4095, 16, FMT_DXT1, 31, 0, 1), 1'b0, '0},
      '{descr(32767, 1, 7, 20, FMT_DXT, 1, 1, 0), 1'b0, '0},
      // odd sizes through every alignment
      '{descr(3, 5, 1, 3, FMT_RAW, 3, 0, 0), 1'b0, '0},
      '{descr(3, 5, 1, 3, FMT_RAW, 3, 1, 0), 1'b0, '0},
      '{descr(3, 5, 1, 3, FMT_RAW, 3, 2, 0), 1'b0, '0},
      '{descr(3, 5, 1, 3, FMT_RAW, 3, 3, 1), 1'b0, '0},
      '{descr(5, 7, 3, 4, FMT_DXT1, 8, 0, 1), 1'b0, '0},
      // level counts above, at and below the ceiling
      '{descr(16384, 16384, 1, 17, FMT_DXT, 0, 0, 0), 1'b0, '0},
      '{descr(1000, 1, 9, 16, FMT_RAW, 31, 2, 1), 1'b0, '0},
      '{descr(1, 1, 1, 31, FMT_DXT_ALT, 16, 1, 1), 1'b0, '0},
      '{descr(16384, 0, 2048, 15, FMT_DXT1, 16, 3, 0), 1'b0, '0}
    };

    // reset
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed
    for (i = 0; i < NumDirected; i++) begin
      gap = (i < 8) ? 0 : $urandom_range(0, 13);
      send_word(directed_rows[i].desc, gap, directed_rows[i].has_golden,
                directed_rows[i].golden);
    end

    // random
    for (i = 0; i < NumRandom; i++) begin
      // let the chain drain completely once
      if (i == NumRandom / 2) begin
        in_valid_i <= 1'b0;
        while (pending_levels.size() != 0) @(negedge clk_i);
      end
      desc.base_width  = pick_extent();
      desc.base_height = pick_extent();
      desc.layer_depth = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 8));
      desc.mip_count   = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      desc.format_kind = 2'($urandom);
      desc.pixel_bytes = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
      desc.align_log2  = 2'($urandom);
      desc.is_animated = 1'($urandom);
      gap = ((i % 64) < 12) ? 0 : $urandom_range(0, 13);
      send_word(desc, gap, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // wait for the last level words, then a little longer
    while (pending_levels.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (fail_count == 0 && pending_levels.size() == 0) begin
      $display("** texture_mip_chain_sizer_core: PASSED **");
    end else begin
      $display("** texture_mip_chain_sizer_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- texture_mip_chain_sizer_core.f -----
hw/rtl/tmcs_pkg.sv
hw/rtl/texture_mip_chain_sizer_core.sv
verif/texture_mip_chain_sizer_core_test.sv
